>>> hw/rtl/bcp_pkg.sv
// bcp_pkg: shared widths, reset curve, status codes and pipeline structs
// for the battery curve percent block. No dependencies.
package bcp_pkg;

    localparam int MV_W      = 14;  // input voltage, millivolts
    localparam int VOLT_W    = 13;  // anchor voltage field
    localparam int PCT_W     = 7;   // percent field
    localparam int STAT_W    = 2;
    localparam int REG_W     = 20;  // anchor register width
    localparam int REG_COUNT = 8;   // anchor registers stored
    localparam int REG_SEL_W = $clog2(REG_COUNT);
    localparam int IDX_W     = 4;   // config index, room for out-of-range codes
    localparam int NUM_W     = 20;  // dividend: t*dp + rounding bias
    localparam int Q_W       = 7;   // quotient never exceeds dp
    localparam int VOLT_LSB  = 7;   // voltage sits above the percent field

    // reset curve: 4200/100 4000/80 3800/60 3600/40 3400/20 3300/10 3000/5 2700/0
    localparam logic [REG_W-1:0] ANCHOR_RESET [REG_COUNT] = '{
        20'd537700, 20'd512080, 20'd486460, 20'd460840,
        20'd435220, 20'd422410, 20'd384005, 20'd345600
    };

    typedef enum logic [STAT_W-1:0] {
        ST_WITHIN = 2'd0,
        ST_TOP    = 2'd1,
        ST_BOTTOM = 2'd2
    } status_t;

    // segment chosen by the select stage
    typedef struct packed {
        status_t             status;
        logic [PCT_W-1:0]    base;   // upper anchor percent (or fixed result)
        logic [PCT_W-1:0]    dp;     // |p(i+1) - p(i)|
        logic                down;   // percent falls along the segment
        logic [VOLT_W-1:0]   t;      // v(i) - mv
        logic [VOLT_W-1:0]   w;      // v(i) - v(i+1), never zero here
    } seg_t;

    // divider result handed to the output stage
    typedef struct packed {
        status_t             status;
        logic [PCT_W-1:0]    base;
        logic                down;
        logic [Q_W-1:0]      q;
    } div_res_t;

endpackage

>>> hw/rtl/bcp_select.sv
// bcp_select: first pipeline stage, top/bottom tests and segment search.
// Depends on bcp_pkg.
module bcp_select
    import bcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [MV_W-1:0]    mv,
    input  logic [REG_W-1:0]   anchors [REG_COUNT],
    output logic               seg_valid,
    output seg_t               seg
);

    localparam int LAST = ANCHOR_COUNT - 1;

    logic [VOLT_W-1:0] volt [ANCHOR_COUNT];
    logic [PCT_W-1:0]  pct  [ANCHOR_COUNT];
    logic              hit  [LAST];
    logic [VOLT_W-1:0] t_ln [LAST];
    logic [VOLT_W-1:0] w_ln [LAST];

    logic  valid_reg;
    seg_t  seg_reg;
    seg_t  seg_next;

    for (genvar k = 0; k < ANCHOR_COUNT; k++) begin : g_anchor
        assign volt[k] = anchors[k][VOLT_LSB +: VOLT_W];
        assign pct[k]  = anchors[k][PCT_W-1:0];
    end

    // one lane per segment, all independent
    for (genvar i = 0; i < LAST; i++) begin : g_lane
        logic [MV_W-1:0] t_full;
        assign hit[i]  = (mv <= {1'b0, volt[i]}) && (mv >= {1'b0, volt[i+1]});
        assign t_full  = {1'b0, volt[i]} - mv;
        assign t_ln[i] = t_full[VOLT_W-1:0];
        assign w_ln[i] = volt[i] - volt[i+1];
    end

    always_comb
    begin
        seg_next = '{status: ST_WITHIN, base: '0, dp: '0, down: 1'b0,
                     t: '0, w: VOLT_W'(1)};
        priority if (mv >= {1'b0, volt[0]})
        begin
            seg_next.status = ST_TOP;
            seg_next.base   = pct[0];
        end
        else if (mv <= {1'b0, volt[LAST]})
        begin
            seg_next.status = ST_BOTTOM;
            seg_next.base   = pct[LAST];
        end
        else
        begin
            // descending sweep so the first holding segment wins
            for (int i = LAST - 1; i >= 0; i--)
            begin
                if (hit[i])
                begin
                    seg_next.base = pct[i];
                    if (w_ln[i] == '0)
                    begin
                        seg_next.dp   = '0;
                        seg_next.down = 1'b0;
                        seg_next.t    = '0;
                        seg_next.w    = VOLT_W'(1);
                    end
                    else
                    begin
                        seg_next.down = (pct[i+1] < pct[i]);
                        seg_next.dp   = (pct[i+1] < pct[i]) ? (pct[i] - pct[i+1])
                                                            : (pct[i+1] - pct[i]);
                        seg_next.t    = t_ln[i];
                        seg_next.w    = w_ln[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg_reg <= seg_next;
        end
    end

    assign seg_valid = valid_reg;
    assign seg       = seg_reg;

endmodule

>>> hw/rtl/bcp_div.sv
// bcp_div: multiply stage then a restoring divider, one quotient bit per stage.
// Depends on bcp_pkg.
module bcp_div
    import bcp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  logic      seg_valid,
    input  seg_t      seg,
    output logic      res_valid,
    output div_res_t  res
);

    // index 0 is the multiply stage, index j+1 is quotient bit stage j
    logic              valid_reg  [Q_W+1];
    logic [NUM_W-1:0]  r_reg      [Q_W+1];
    logic [Q_W-1:0]    q_reg      [Q_W+1];
    logic [VOLT_W-1:0] w_reg      [Q_W+1];
    logic [PCT_W-1:0]  base_reg   [Q_W+1];
    logic              down_reg   [Q_W+1];
    status_t           status_reg [Q_W+1];

    logic [NUM_W-1:0]  num_next;

    // falling segments round toward minus infinity via a ceiling divide
    assign num_next = NUM_W'(seg.t) * NUM_W'(seg.dp)
                    + (seg.down ? (NUM_W'(seg.w) - NUM_W'(1)) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]      <= num_next;
            q_reg[0]      <= '0;
            w_reg[0]      <= seg.w;
            base_reg[0]   <= seg.base;
            down_reg[0]   <= seg.down;
            status_reg[0] <= seg.status;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_bit
        localparam int K = Q_W - 1 - j;
        logic [NUM_W-1:0] dsh;
        logic             ge;
        logic [NUM_W-1:0] r_next;
        logic [Q_W-1:0]   q_next;

        assign dsh    = {{(NUM_W-VOLT_W){1'b0}}, w_reg[j]} << K;
        assign ge     = (r_reg[j] >= dsh);
        assign r_next = ge ? (r_reg[j] - dsh) : r_reg[j];
        assign q_next = ge ? (q_reg[j] | (Q_W'(1) << K)) : q_reg[j];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                valid_reg[j+1] <= valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                r_reg[j+1]      <= r_next;
                q_reg[j+1]      <= q_next;
                w_reg[j+1]      <= w_reg[j];
                base_reg[j+1]   <= base_reg[j];
                down_reg[j+1]   <= down_reg[j];
                status_reg[j+1] <= status_reg[j];
            end
        end
    end

    assign res_valid  = valid_reg[Q_W];
    assign res.status = status_reg[Q_W];
    assign res.base   = base_reg[Q_W];
    assign res.down   = down_reg[Q_W];
    assign res.q      = q_reg[Q_W];

endmodule

>>> hw/rtl/battery_curve_percent.sv
// battery_curve_percent: top level, anchor registers, pipeline control and
// output stage. Depends on bcp_pkg, bcp_select and bcp_div.
//
// Usage:
//   Voltage samples (millivolts) come in on the s_axis stream, one item per
//   transfer. Each gives one result item on m_axis: the floored charge
//   percent in tdata and the range status in tuser (within curve, at or
//   above top, at or below bottom).
//   The curve is eight anchors written through cfg_we/cfg_index/cfg_wdata,
//   each voltage*128 + percent; only the first ANCHOR_COUNT take part.
//   Index 8 and up is dropped. Write anchors only while the pipe is empty.
//   Pipeline: select stage, multiply stage, seven divider stages (one
//   quotient bit each, set by the 20-bit compare/subtract), output register.
//   Throughput: one item per cycle, sustained while m_axis_tready keeps
//   the output item moving.
//   Stall: when the output item is held by m_axis_tready low, every stage
//   freezes and s_axis_tready drops in the same cycle; nothing is lost or
//   duplicated. Ready returns as soon as the output item is taken.
//   Reset: rst_n clears all valid bits and loads the default 8-point curve.
module battery_curve_percent
    import bcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [13:0] battery_mv, [15:14] zero
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [6:0] charge_percent, [7] zero
    output logic [STAT_W-1:0] m_axis_tuser,   // [1:0] range_status
    // configuration
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_wdata
);

    logic [REG_W-1:0] anchor_reg [REG_COUNT];

    logic             adv;
    logic             seg_valid;
    seg_t             seg;
    logic             res_valid;
    div_res_t         res;

    logic             out_valid_reg;
    logic [PCT_W-1:0] out_pct_reg;
    logic [PCT_W-1:0] out_pct_next;
    status_t          out_status_reg;

    // whole pipe moves together unless the output item is blocked
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // anchor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_COUNT; k++)
            begin
                anchor_reg[k] <= ANCHOR_RESET[k];
            end
        end
        else if (cfg_we && (cfg_index < IDX_W'(REG_COUNT)))
        begin
            anchor_reg[cfg_index[REG_SEL_W-1:0]] <= cfg_wdata;
        end
    end

    bcp_select #(
        .ANCHOR_COUNT (ANCHOR_COUNT)
    ) u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .mv        (s_axis_tdata[MV_W-1:0]),
        .anchors   (anchor_reg),
        .seg_valid (seg_valid),
        .seg       (seg)
    );

    bcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .seg_valid (seg_valid),
        .seg       (seg),
        .res_valid (res_valid),
        .res       (res)
    );

    // final step: apply the quotient to the upper anchor percent
    assign out_pct_next = res.down ? (res.base - res.q) : (res.base + res.q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_pct_reg    <= out_pct_next;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_pct_reg};
    assign m_axis_tuser  = out_status_reg;

    // a result only carries one of the defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == ST_WITHIN) || (m_axis_tuser == ST_TOP)
                           || (m_axis_tuser == ST_BOTTOM)))
        else $error("undefined range status code on output");

    // clamped results must not interpolate
    a_clamp_no_slope: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && (seg.status != ST_WITHIN)) |-> (seg.dp == '0))
        else $error("clamped item carries a nonzero slope");

    // a blocked output freezes the internal stages too
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            ((seg_valid == $past(seg_valid)) && (res_valid == $past(res_valid))))
        else $error("pipeline moved during output stall");

endmodule

>>> test/battery_curve_percent_check.sv
// battery_curve_percent_check: watches the voltage, result and anchor write
// channels of battery_curve_percent, predicts each charge level and compares.
// Depends on bcp_pkg.
module battery_curve_percent_check
    import bcp_pkg::*;
#(
    parameter int ANCHOR_COUNT = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // [13:0] battery_mv, [15:14] zero
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,   // [6:0] charge_percent, [7] zero
    input  logic [STAT_W-1:0] m_axis_tuser,   // [1:0] range_status
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [REG_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending,
    output int                results_seen
);

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        status_t          status;
    } level_t;

    logic [REG_W-1:0] curve_regs [REG_COUNT];
    level_t           expected_levels [$];
    int               errors;
    int               checked;

    function automatic int unsigned volt_of(int k);
        return int'(curve_regs[k][REG_W-1:VOLT_LSB]);
    endfunction

    function automatic int unsigned pct_of(int k);
        return int'(curve_regs[k][PCT_W-1:0]);
    endfunction

    // Charge level for one voltage under the current curve.
    function automatic level_t predict_level(int unsigned mv);
        level_t      r;
        int unsigned last;
        int unsigned hi_v;
        int unsigned lo_v;
        int unsigned hi_p;
        int unsigned lo_p;
        int unsigned span;
        int unsigned run;
        int unsigned level;
        int          i;
        bit          found;
        r.pct    = '0;
        r.status = ST_WITHIN;
        last     = ANCHOR_COUNT - 1;
        found    = 1'b0;
        level    = 0;
        if (mv >= volt_of(0)) begin
            r.pct    = PCT_W'(pct_of(0));
            r.status = ST_TOP;
        end
        else if (mv <= volt_of(last)) begin
            r.pct    = PCT_W'(pct_of(last));
            r.status = ST_BOTTOM;
        end
        else begin
            // first segment holding mv; none found leaves 0 / within
            for (i = 0; i < last && !found; i++) begin
                hi_v = volt_of(i);
                lo_v = volt_of(i + 1);
                if (mv <= hi_v && mv >= lo_v) begin
                    found = 1'b1;
                    hi_p  = pct_of(i);
                    lo_p  = pct_of(i + 1);
                    span  = hi_v - lo_v;
                    run   = hi_v - mv;
                    if (span == 0)
                        level = hi_p;
                    else if (lo_p >= hi_p)
                        level = hi_p + (run * (lo_p - hi_p)) / span;
                    else
                        level = hi_p - (run * (hi_p - lo_p) + span - 1) / span;
                end
            end
            r.pct = PCT_W'(level);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        level_t want;
        if (!rst_n) begin
            for (int k = 0; k < REG_COUNT; k++)
                curve_regs[k] = ANCHOR_RESET[k];
            expected_levels.delete();
            errors  = 0;
            checked = 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                checked++;
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result item, tdata %0d tuser %0d",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata !== {1'b0, want.pct}) begin
                        errors++;
                        $display("%0t: charge_percent mismatch, expected %0d, actual %0d",
                                 $time, {1'b0, want.pct}, m_axis_tdata);
                    end
                    if (m_axis_tuser !== want.status) begin
                        errors++;
                        $display("%0t: range_status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_levels.push_back(predict_level(s_axis_tdata[MV_W-1:0]));
            // indexes past the last register are dropped
            if (cfg_we && cfg_index < REG_COUNT)
                curve_regs[cfg_index[REG_SEL_W-1:0]] = cfg_wdata;
        end
        fail_count   <= errors;
        pending      <= expected_levels.size();
        results_seen <= checked;
    end

endmodule

>>> test/battery_curve_percent_test.sv
// battery_curve_percent_test: top of the testbench. Drives voltage items and
// anchor writes into battery_curve_percent and gives the verdict.
// Depends on bcp_pkg, battery_curve_percent and battery_curve_percent_check.
module battery_curve_percent_test;
    import bcp_pkg::*;

    localparam int CURVE_POINTS  = 8;
    localparam int PIPE_LATENCY  = 10;    // accept edge to result valid
    localparam int QUIET_LIMIT   = 2000;  // cycles with no item moving
    localparam int HOLD_CYCLES   = 64;    // long receiver hold-off
    localparam int HOLD_AFTER    = 500;   // results before the hold-off
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int STEADY_PHASE  = 3;     // phase run with no idling
    localparam int MV_MAX        = (1 << MV_W) - 1;
    localparam int VOLT_MAX      = (1 << VOLT_W) - 1;
    localparam int PCT_MAX       = (1 << PCT_W) - 1;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;    // [13:0] battery_mv, [15:14] zero
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;          // [6:0] charge_percent, [7] zero
    logic [STAT_W-1:0] m_axis_tuser;          // [1:0] range_status
    logic              cfg_we        = 1'b0;
    logic [IDX_W-1:0]  cfg_index     = '0;
    logic [REG_W-1:0]  cfg_wdata     = '0;

    int  fail_count;
    int  pending;
    int  results_seen;
    bit  no_idle     = 1'b0;   // both sides run flat out while set
    bit  holding_off = 1'b0;   // receiver is in its long hold-off
    int  items_sent  = 0;
    int  curves_loaded = 0;

    // curve currently loaded (or about to be), one packed anchor per entry
    logic [REG_W-1:0] curve [CURVE_POINTS];

    always #10 clk = ~clk;

    battery_curve_percent #(.ANCHOR_COUNT(CURVE_POINTS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    battery_curve_percent_check #(.ANCHOR_COUNT(CURVE_POINTS)) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    // anchor register layout: voltage above, percent in the low bits
    function automatic logic [REG_W-1:0] pack_anchor(int mv, int pct);
        return {mv[VOLT_W-1:0], pct[PCT_W-1:0]};
    endfunction

    // One voltage item. Random idle gaps go in front of it (not while the
    // receiver is holding off, so the pipe really fills), then valid holds
    // until the accept edge. Valid is left high for the next item.
    task automatic send_mv(int unsigned mv);
        if (!no_idle && !holding_off) begin
            while ($urandom_range(99) < 33 && !holding_off) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, mv[MV_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Wait for the pipe to empty. The first edge lets the count from the
    // last accept settle before it is trusted.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Write all anchors of `curve`, now and then followed by a write to an
    // index past the register file, which the block must drop.
    task automatic load_curve();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        for (int k = 0; k < CURVE_POINTS; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(k);
            cfg_wdata <= curve[k];
            @(posedge clk);
        end
        if ($urandom_range(1)) begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(REG_COUNT + $urandom_range((1 << IDX_W) - 1 - REG_COUNT));
            cfg_wdata <= REG_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        curves_loaded++;
    endtask

    // Random curve: mostly falling voltages with random percents (so both
    // falling and rising percent segments), some rising (reversed) curves,
    // some raw register noise. Repeated voltages give zero-width segments.
    task automatic make_random_curve();
        int style;
        int spread;
        int v;
        int drop;
        style  = $urandom_range(19);
        spread = $urandom_range(1500);
        v      = $urandom_range(VOLT_MAX);
        for (int k = 0; k < CURVE_POINTS; k++) begin
            if (style < 3) begin
                curve[k] = REG_W'($urandom);
            end
            else begin
                curve[k] = pack_anchor(v, $urandom_range(PCT_MAX));
                drop = ($urandom_range(5) == 0) ? 0 : $urandom_range(spread);
                if (style < 6)
                    v = (v + drop > VOLT_MAX) ? VOLT_MAX : v + drop;
                else
                    v = (v - drop < 0) ? 0 : v - drop;
            end
        end
    endtask

    // Voltage for a random item: near the loaded curve most of the time,
    // right at an anchor voltage (+/-1) often, the full 14-bit range some.
    function automatic int unsigned pick_mv();
        int lo;
        int hi;
        int v;
        lo = VOLT_MAX;
        hi = 0;
        for (int k = 0; k < CURVE_POINTS; k++) begin
            v = int'(curve[k][REG_W-1:VOLT_LSB]);
            if (v < lo) lo = v;
            if (v > hi) hi = v;
        end
        case ($urandom_range(9))
            0, 1: return $urandom_range(MV_MAX);
            2, 3:
            begin
                v = int'(curve[$urandom_range(CURVE_POINTS - 1)][REG_W-1:VOLT_LSB]);
                v = v + int'($urandom_range(2)) - 1;
                return (v < 0) ? 0 : v;
            end
            default:
            begin
                lo = (lo < 20) ? 0 : lo - 20;
                hi = hi + 20;
                return $urandom_range(hi, lo);
            end
        endcase
    endfunction

    // Receiver: random stalls, none while no_idle is set, and one long
    // hold-off once enough results have been seen, as counted by the checker.
    initial begin : result_sink
        bit held;
        held = 1'b0;
        @(posedge clk);
        forever begin
            if (!held && results_seen >= HOLD_AFTER) begin
                held          = 1'b1;
                holding_off   = 1'b1;
                m_axis_tready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
                holding_off = 1'b0;
            end
            m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
            @(posedge clk);
        end
    end

    // Watchdog: too long with nothing accepted on either side ends the run.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("battery_curve_percent_test: done, errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned default_pts [12];
        int unsigned shape_v [CURVE_POINTS];
        int unsigned shape_p [CURVE_POINTS];
        // reset curve: below and at bottom, segment edges, top and beyond
        default_pts = '{0, 2699, 2700, 2701, 2850, 3399,
                        3450, 3999, 4199, 4200, 4201, MV_MAX};
        curve = ANCHOR_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: reset curve, nothing written yet
        foreach (default_pts[k])
            send_mv(default_pts[k]);

        // percent rising toward the bottom, top anchor at full scale
        shape_v = '{VOLT_MAX, 7000, 6000, 5000, 4000, 3000, 1000, 0};
        shape_p = '{0, 10, 30, 50, 64, 90, 100, PCT_MAX};
        foreach (curve[k]) curve[k] = pack_anchor(shape_v[k], shape_p[k]);
        load_curve();
        send_mv(0);
        send_mv(VOLT_MAX);
        send_mv(6500);

        // repeated voltages: zero-width segments, at top and inside
        shape_v = '{4000, 4000, 3500, 3500, 3000, 3000, 2800, 2500};
        shape_p = '{100, 90, 70, 50, 30, 25, 5, 0};
        foreach (curve[k]) curve[k] = pack_anchor(shape_v[k], shape_p[k]);
        load_curve();
        send_mv(4000);
        send_mv(3500);
        send_mv(3000);

        // reversed: top voltage under the bottom one, top test wins
        shape_v = '{1000, 2000, 3000, 3500, 4000, 4500, 4800, 5000};
        shape_p = '{11, 20, 30, 40, 50, 60, 70, 77};
        foreach (curve[k]) curve[k] = pack_anchor(shape_v[k], shape_p[k]);
        load_curve();
        send_mv(3000);
        send_mv(500);
        send_mv(6000);

        // unordered anchors inside the curve
        shape_v = '{5000, 2000, 4500, 1500, 4800, 1200, 3000, 1000};
        shape_p = '{50, 20, 45, 99, 3, 127, 64, 10};
        foreach (curve[k]) curve[k] = pack_anchor(shape_v[k], shape_p[k]);
        load_curve();
        send_mv(3000);
        send_mv(4700);
        send_mv(1100);

        // every register all ones, then all zeros
        foreach (curve[k]) curve[k] = '1;
        load_curve();
        send_mv(VOLT_MAX - 1);
        send_mv(VOLT_MAX);
        foreach (curve[k]) curve[k] = '0;
        load_curve();
        send_mv(0);

        // --- random curves with random voltages
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            make_random_curve();
            load_curve();
            no_idle = (phase == STEADY_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_mv(pick_mv());
            no_idle = 1'b0;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (PIPE_LATENCY) @(posedge clk);

        $display("covered %0d voltage items over %0d loaded curves plus the reset curve, %0d results checked",
                 items_sent, curves_loaded, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("battery_curve_percent_test: done, clean");
        else
            $display("battery_curve_percent_test: done, errors");
        $finish;
    end

endmodule
